### src/mspd_pkg.sv
`default_nettype none

package mspd_pkg;

  localparam int HEADER_BYTES = 18;
  localparam int MAGIC_BYTES  = 4;
  localparam int HDR_IDX_W    = $clog2(HEADER_BYTES);

  // Offsets inside the header.
  localparam int OFS_VERSION = 4;
  localparam int OFS_TYPE    = 5;
  localparam int OFS_WIDTH   = 6;
  localparam int OFS_HEIGHT  = 8;
  localparam int OFS_SEQ     = 10;
  localparam int OFS_SIZE    = 14;

  localparam logic [7:0] MAGIC_0 = 8'h54;  // 'T'
  localparam logic [7:0] MAGIC_1 = 8'h4C;  // 'L'
  localparam logic [7:0] MAGIC_2 = 8'h49;  // 'I'
  localparam logic [7:0] MAGIC_3 = 8'h4D;  // 'M'

  // Configuration register indexes.
  localparam logic REG_EXPECTED_VERSION = 1'b0;
  localparam logic REG_PAYLOAD_LIMIT    = 1'b1;

  localparam logic [7:0]  VERSION_RESET = 8'd1;
  localparam logic [31:0] LIMIT_RESET   = 32'd2097152;

  localparam logic KIND_HEADER  = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic        item_kind;
    logic [7:0]  image_type;
    logic [15:0] frame_width;
    logic [15:0] frame_height;
    logic [31:0] sequence_number;
    logic [31:0] payload_length;
    logic [7:0]  data_byte;
    logic        last;
  } result_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0: b = MAGIC_0;
      2'd1: b = MAGIC_1;
      2'd2: b = MAGIC_2;
      2'd3: b = MAGIC_3;
      default: b = MAGIC_0;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

### src/mspd_front.sv
`default_nettype none

module mspd_front
  import mspd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic [7:0]  in_byte,
  input  wire logic [7:0]  expected_version,
  input  wire logic [31:0] payload_limit,
  output logic             busy,
  output logic             res_valid,
  output result_t          res
);

  localparam logic [1:0] PH_HUNT    = 2'd0;
  localparam logic [1:0] PH_HEADER  = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;

  localparam logic [HDR_IDX_W-1:0] LAST_HDR_IDX = HDR_IDX_W'(HEADER_BYTES - 1);
  localparam logic [HDR_IDX_W-1:0] REPLAY_START = HDR_IDX_W'(OFS_VERSION);
  localparam logic [HDR_IDX_W-1:0] MAGIC_CNT    = HDR_IDX_W'(MAGIC_BYTES);

  logic [1:0]           phase_r, phase_nxt;
  logic [HDR_IDX_W-1:0] hdr_cnt_r, hdr_cnt_nxt;
  logic [1:0]           match_r, match_nxt;
  logic [31:0]          remain_r, remain_nxt;
  logic                 replay_r, replay_nxt;
  logic [HDR_IDX_W-1:0] replay_idx_r, replay_idx_nxt;
  logic [7:0]           hdr_r [HEADER_BYTES];

  logic        step;
  logic [7:0]  cur_byte;
  logic        st_we;
  logic        magic_load;
  logic [31:0] size;
  logic        reject;

  assign step     = replay_r | in_valid;
  assign cur_byte = replay_r ? hdr_r[replay_idx_r] : in_byte;
  assign busy     = replay_r;
  // Last size byte comes straight from the current beat.
  assign size     = {cur_byte, hdr_r[OFS_SIZE+2], hdr_r[OFS_SIZE+1], hdr_r[OFS_SIZE]};
  assign reject   = (hdr_r[OFS_VERSION] != expected_version) || (size > payload_limit);

  always_comb begin
    phase_nxt      = phase_r;
    hdr_cnt_nxt    = hdr_cnt_r;
    match_nxt      = match_r;
    remain_nxt     = remain_r;
    replay_nxt     = replay_r;
    replay_idx_nxt = replay_idx_r;
    st_we          = 1'b0;
    magic_load     = 1'b0;
    res_valid      = 1'b0;
    res            = '0;

    if (replay_r) begin
      if (replay_idx_r == LAST_HDR_IDX) begin
        replay_nxt     = 1'b0;
        replay_idx_nxt = '0;
      end else begin
        replay_idx_nxt = replay_idx_r + 1'b1;
      end
    end

    if (step) begin
      case (phase_r)
        PH_PAYLOAD: begin
          res_valid      = 1'b1;
          res.item_kind  = KIND_PAYLOAD;
          res.data_byte  = cur_byte;
          remain_nxt     = remain_r - 1'b1;
          if (remain_r <= 32'd1) begin
            remain_nxt  = '0;
            res.last    = 1'b1;
            phase_nxt   = PH_HUNT;
            match_nxt   = '0;
            hdr_cnt_nxt = '0;
          end
        end
        PH_HEADER: begin
          st_we       = 1'b1;
          hdr_cnt_nxt = hdr_cnt_r + 1'b1;
          if (hdr_cnt_r == LAST_HDR_IDX) begin
            hdr_cnt_nxt = '0;
            match_nxt   = '0;
            if (reject) begin
              // Rescan held bytes from byte 4 on; bytes 1 to 3 cannot start a match, so skip them.
              phase_nxt      = PH_HUNT;
              replay_nxt     = 1'b1;
              replay_idx_nxt = REPLAY_START;
            end else begin
              res_valid           = 1'b1;
              res.item_kind       = KIND_HEADER;
              res.image_type      = hdr_r[OFS_TYPE];
              res.frame_width     = {hdr_r[OFS_WIDTH+1], hdr_r[OFS_WIDTH]};
              res.frame_height    = {hdr_r[OFS_HEIGHT+1], hdr_r[OFS_HEIGHT]};
              res.sequence_number = {hdr_r[OFS_SEQ+3], hdr_r[OFS_SEQ+2],
                                     hdr_r[OFS_SEQ+1], hdr_r[OFS_SEQ]};
              res.payload_length  = size;
              if (size == '0) begin
                res.last  = 1'b1;
                phase_nxt = PH_HUNT;
              end else begin
                remain_nxt = size;
                phase_nxt  = PH_PAYLOAD;
              end
            end
          end
        end
        default: begin
          phase_nxt = PH_HUNT;
          if (cur_byte == magic_byte(match_r)) begin
            if (match_r == 2'd3) begin
              magic_load  = 1'b1;
              hdr_cnt_nxt = MAGIC_CNT;
              match_nxt   = '0;
              phase_nxt   = PH_HEADER;
            end else begin
              match_nxt = match_r + 1'b1;
            end
          end else begin
            match_nxt = (cur_byte == MAGIC_0) ? 2'd1 : 2'd0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HUNT;
      hdr_cnt_r    <= '0;
      match_r      <= '0;
      remain_r     <= '0;
      replay_r     <= 1'b0;
      replay_idx_r <= '0;
    end else begin
      phase_r      <= phase_nxt;
      hdr_cnt_r    <= hdr_cnt_nxt;
      match_r      <= match_nxt;
      remain_r     <= remain_nxt;
      replay_r     <= replay_nxt;
      replay_idx_r <= replay_idx_nxt;
    end
  end

  // Writes always land below the replay read index, so rescanning in place is safe.
  always_ff @(posedge clk) begin
    if (st_we) begin
      hdr_r[hdr_cnt_r] <= cur_byte;
    end
    if (magic_load) begin
      for (int i = 0; i < MAGIC_BYTES; i++) begin
        hdr_r[i] <= magic_byte(2'(i));
      end
    end
  end

endmodule

`default_nettype wire

### src/mspd_queue.sv
`default_nettype none

module mspd_queue
  import mspd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    wr_en,
  input  wire result_t wr_data,
  input  wire logic    rd_en,
  output logic         q_full,
  output logic         q_empty,
  output result_t      rd_data
);

  result_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wptr_r, rptr_r;
  logic [QPTR_W:0]     cnt_r, cnt_nxt;
  logic                do_wr, do_rd;

  assign q_full  = (cnt_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign q_empty = (cnt_r == '0);
  assign do_wr   = wr_en & ~q_full;
  assign do_rd   = rd_en & ~q_empty;
  assign rd_data = mem_r[rptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_wr) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (do_rd) begin
        rptr_r <= rptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

### src/magic_sync_packet_deframer_unit.sv
`default_nettype none

// Magic-sync packet deframer. Bytes pushed on in_rx_byte are scanned for the
// magic "TLIM"; the following bytes complete an 18-byte header (magic, version,
// type, width16, height16, sequence32, size32, all little-endian). A header whose
// version differs from expected_version (cfg index 0) or whose size exceeds
// payload_limit (cfg index 1) is dropped and its bytes after the magic are
// rescanned for a new magic. An accepted header yields one header beat
// (item_kind 0), then each payload byte yields one payload beat (item_kind 1)
// with last high on the final byte; a zero-size header beat carries last itself.
// Rate: one byte per cycle while full is low. A rejected header holds full
// high while the parser rescans its stored header bytes, one per cycle; full
// also rises when the 4-entry result queue fills. A result enters the queue
// the cycle after the byte that caused it. Configuration takes effect at the
// next header check and should be written while the block is idle.

module magic_sync_packet_deframer_unit
  import mspd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  in_rx_byte,
  // result channel
  output logic             empty,
  input  wire logic        pop,
  output logic             out_item_kind,
  output logic [7:0]       out_image_type,
  output logic [15:0]      out_frame_width,
  output logic [15:0]      out_frame_height,
  output logic [31:0]      out_sequence_number,
  output logic [31:0]      out_payload_length,
  output logic [7:0]       out_data_byte,
  output logic             out_last,
  // configuration
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data
);

  logic [7:0]  version_r;
  logic [31:0] limit_r;

  logic    front_busy;
  logic    res_valid;
  result_t res;
  logic    q_full;
  result_t head;

  // Hold input while rescanning or when the queue has no room for a result.
  assign full = front_busy | q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      version_r <= VERSION_RESET;
      limit_r   <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_EXPECTED_VERSION: version_r <= cfg_data[7:0];
        REG_PAYLOAD_LIMIT:    limit_r   <= cfg_data;
        default:              limit_r   <= limit_r;
      endcase
    end
  end

  mspd_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (push & ~full),
    .in_byte          (in_rx_byte),
    .expected_version (version_r),
    .payload_limit    (limit_r),
    .busy             (front_busy),
    .res_valid        (res_valid),
    .res              (res)
  );

  mspd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_valid),
    .wr_data (res),
    .rd_en   (pop),
    .q_full  (q_full),
    .q_empty (empty),
    .rd_data (head)
  );

  assign out_item_kind       = head.item_kind;
  assign out_image_type      = head.image_type;
  assign out_frame_width     = head.frame_width;
  assign out_frame_height    = head.frame_height;
  assign out_sequence_number = head.sequence_number;
  assign out_payload_length  = head.payload_length;
  assign out_data_byte       = head.data_byte;
  assign out_last            = head.last;

endmodule

`default_nettype wire

### tb/deframer_checker.sv
`default_nettype none

module deframer_checker
  import mspd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire logic        full,
  input  wire logic [7:0]  in_rx_byte,
  input  wire logic        empty,
  input  wire logic        pop,
  input  wire logic        out_item_kind,
  input  wire logic [7:0]  out_image_type,
  input  wire logic [15:0] out_frame_width,
  input  wire logic [15:0] out_frame_height,
  input  wire logic [31:0] out_sequence_number,
  input  wire logic [31:0] out_payload_length,
  input  wire logic [7:0]  out_data_byte,
  input  wire logic        out_last,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data,
  output int               fail_count,
  output int               pending,
  output int               beats_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {HUNTING, IN_HEADER, IN_PAYLOAD} parse_stage_e;

  localparam logic [31:0] SYNC_WORD = {MAGIC_3, MAGIC_2, MAGIC_1, MAGIC_0};

  parse_stage_e stage;
  logic [7:0]   hdr_bytes [HEADER_BYTES];
  int           hdr_fill;
  int           magic_seen;
  logic [31:0]  bytes_left;
  logic [7:0]   want_version;
  logic [31:0]  size_cap;
  result_t      expected_beats [$];

  initial begin
    fail_count    = 0;
    pending       = 0;
    beats_checked = 0;
  end

  // Parse one byte; returns 1 when it yields a result beat.
  function automatic bit parse_byte(input logic [7:0] b, output result_t r,
                                    output bit dropped);
    logic [31:0] size;
    r       = '0;
    dropped = 1'b0;
    case (stage)
      IN_PAYLOAD: begin
        r.item_kind = KIND_PAYLOAD;
        r.data_byte = b;
        if (bytes_left != 0) bytes_left--;
        if (bytes_left == 0) begin
          r.last     = 1'b1;
          stage      = HUNTING;
          magic_seen = 0;
          hdr_fill   = 0;
        end
        return 1'b1;
      end
      IN_HEADER: begin
        hdr_bytes[hdr_fill] = b;
        hdr_fill++;
        if (hdr_fill < HEADER_BYTES) return 1'b0;
        size = {hdr_bytes[OFS_SIZE+3], hdr_bytes[OFS_SIZE+2],
                hdr_bytes[OFS_SIZE+1], hdr_bytes[OFS_SIZE]};
        hdr_fill   = 0;
        magic_seen = 0;
        if (hdr_bytes[OFS_VERSION] != want_version || size > size_cap) begin
          stage   = HUNTING;
          dropped = 1'b1;
          return 1'b0;
        end
        r.item_kind       = KIND_HEADER;
        r.image_type      = hdr_bytes[OFS_TYPE];
        r.frame_width     = {hdr_bytes[OFS_WIDTH+1], hdr_bytes[OFS_WIDTH]};
        r.frame_height    = {hdr_bytes[OFS_HEIGHT+1], hdr_bytes[OFS_HEIGHT]};
        r.sequence_number = {hdr_bytes[OFS_SEQ+3], hdr_bytes[OFS_SEQ+2],
                             hdr_bytes[OFS_SEQ+1], hdr_bytes[OFS_SEQ]};
        r.payload_length  = size;
        if (size == 0) begin
          r.last = 1'b1;
          stage  = HUNTING;
        end else begin
          bytes_left = size;
          stage      = IN_PAYLOAD;
        end
        return 1'b1;
      end
      default: begin
        stage = HUNTING;
        if (magic_seen < MAGIC_BYTES && b == SYNC_WORD[8*magic_seen +: 8])
          magic_seen++;
        else
          magic_seen = (b == MAGIC_0) ? 1 : 0;
        if (magic_seen >= MAGIC_BYTES) begin
          for (int i = 0; i < MAGIC_BYTES; i++) hdr_bytes[i] = SYNC_WORD[8*i +: 8];
          hdr_fill   = MAGIC_BYTES;
          magic_seen = 0;
          stage      = IN_HEADER;
        end
        return 1'b0;
      end
    endcase
  endfunction

  // A dropped header gets its stored bytes after the first one scanned again.
  function automatic void take_byte(input logic [7:0] b);
    result_t    r;
    result_t    scratch;
    bit         dropped;
    bit         again;
    logic [7:0] held [HEADER_BYTES];
    if (parse_byte(b, r, dropped)) expected_beats.push_back(r);
    if (dropped) begin
      held = hdr_bytes;
      for (int i = 1; i < HEADER_BYTES; i++) void'(parse_byte(held[i], scratch, again));
    end
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      stage        = HUNTING;
      hdr_fill     = 0;
      magic_seen   = 0;
      bytes_left   = '0;
      want_version = VERSION_RESET;
      size_cap     = LIMIT_RESET;
      expected_beats.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_EXPECTED_VERSION: want_version = cfg_data[7:0];
          REG_PAYLOAD_LIMIT:    size_cap     = cfg_data;
          default: ;
        endcase
      end
      // compare first, so a beat can never match a prediction made this edge
      if (pop && !empty) begin
        beats_checked++;
        if (expected_beats.size() == 0) begin
          $error("result beat arrived with no prediction waiting");
          fail_count++;
        end else begin
          want = expected_beats.pop_front();
          check_field("item_kind", 32'(want.item_kind), 32'(out_item_kind));
          check_field("image_type", 32'(want.image_type), 32'(out_image_type));
          check_field("frame_width", 32'(want.frame_width), 32'(out_frame_width));
          check_field("frame_height", 32'(want.frame_height), 32'(out_frame_height));
          check_field("sequence_number", want.sequence_number, out_sequence_number);
          check_field("payload_length", want.payload_length, out_payload_length);
          check_field("data_byte", 32'(want.data_byte), 32'(out_data_byte));
          check_field("last", 32'(want.last), 32'(out_last));
        end
      end
      if (push && !full) take_byte(in_rx_byte);
    end
    pending = expected_beats.size();
  end

endmodule

`default_nettype wire

### tb/tb.sv
`default_nettype none

module tb;
  import mspd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles to let pass after the last predicted beat: covers a header replay
  // and the registered result path, with margin.
  localparam int SETTLE_CYCLES = 32;
  localparam logic [31:0] SYNC_WORD = {MAGIC_3, MAGIC_2, MAGIC_1, MAGIC_0};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        empty;
  logic        pop = 1'b0;
  logic        out_item_kind;
  logic [7:0]  out_image_type;
  logic [15:0] out_frame_width;
  logic [15:0] out_frame_height;
  logic [31:0] out_sequence_number;
  logic [31:0] out_payload_length;
  logic [7:0]  out_data_byte;
  logic        out_last;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_index = REG_EXPECTED_VERSION;
  logic [31:0] cfg_data = '0;

  int fail_count;
  int pending;
  int beats_checked;

  // Stimulus knobs, shared with the receiver process.
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int rx_stall_req = 0;

  // Generator view of the current configuration.
  logic [7:0]  cur_version = VERSION_RESET;
  logic [31:0] cur_limit = LIMIT_RESET;

  logic [7:0] stream_q [$];
  int bytes_sent = 0;
  int packets_built = 0;
  int headers_dropped = 0;
  int settings_used = 1;

  magic_sync_packet_deframer_unit u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .push                (push),
    .full                (full),
    .in_rx_byte          (in_rx_byte),
    .empty               (empty),
    .pop                 (pop),
    .out_item_kind       (out_item_kind),
    .out_image_type      (out_image_type),
    .out_frame_width     (out_frame_width),
    .out_frame_height    (out_frame_height),
    .out_sequence_number (out_sequence_number),
    .out_payload_length  (out_payload_length),
    .out_data_byte       (out_data_byte),
    .out_last            (out_last),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  deframer_checker u_check (
    .clk                 (clk),
    .rst_n               (rst_n),
    .push                (push),
    .full                (full),
    .in_rx_byte          (in_rx_byte),
    .empty               (empty),
    .pop                 (pop),
    .out_item_kind       (out_item_kind),
    .out_image_type      (out_image_type),
    .out_frame_width     (out_frame_width),
    .out_frame_height    (out_frame_height),
    .out_sequence_number (out_sequence_number),
    .out_payload_length  (out_payload_length),
    .out_data_byte       (out_data_byte),
    .out_last            (out_last),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .fail_count          (fail_count),
    .pending             (pending),
    .beats_checked       (beats_checked)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Receiver: random pop idling, plus a long hold-off on request. The hold is
  // counted here so the sender keeps offering bytes while the block backs up.
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rx_stall_req != 0) begin
        stall_left   = rx_stall_req;
        rx_stall_req = 0;
      end
      if (!rst_n) begin
        pop <= 1'b0;
      end else if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        pop <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Append n bytes of v, least significant first.
  function automatic void put_le(input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++) stream_q.push_back(v[8*i +: 8]);
  endfunction

  function automatic void put_header(input logic [7:0] ver, input logic [7:0] kind,
                                     input logic [15:0] w, input logic [15:0] h,
                                     input logic [31:0] seq, input logic [31:0] size);
    put_le(SYNC_WORD, MAGIC_BYTES);
    stream_q.push_back(ver);
    stream_q.push_back(kind);
    put_le(w, 2);
    put_le(h, 2);
    put_le(seq, 4);
    put_le(size, 4);
  endfunction

  function automatic void put_payload(input logic [31:0] n);
    for (int i = 0; i < n; i++) stream_q.push_back(8'($urandom_range(255)));
  endfunction

  // Mostly short payloads, sometimes empty, never above the current limit.
  function automatic logic [31:0] pick_size();
    logic [31:0] cap;
    cap = (cur_limit < 12) ? cur_limit : 32'd12;
    if ($urandom_range(7) == 0) return '0;
    return $urandom_range(cap, 0);
  endfunction

  function automatic void put_good_packet(input logic [31:0] size);
    put_header(cur_version, 8'($urandom_range(255)), 16'($urandom_range(65535)),
               16'($urandom_range(65535)), $urandom, size);
    put_payload(size);
    packets_built++;
  endfunction

  function automatic void put_bad_version();
    put_header(cur_version ^ 8'($urandom_range(255, 1)), 8'($urandom_range(255)),
               16'($urandom_range(65535)), 16'($urandom_range(65535)), $urandom, $urandom);
    packets_built++;
    headers_dropped++;
  endfunction

  // Oversize header: just past the limit or above it; bad version at max.
  function automatic void put_bad_size();
    logic [31:0] lo;
    logic [31:0] size;
    if (cur_limit == 32'hFFFF_FFFF) begin
      put_bad_version();
    end else begin
      lo = cur_limit + 1;
      if ($urandom_range(1) == 0) size = lo;
      else size = lo + ($urandom % (32'hFFFF_FFFF - lo + 1));
      put_header(cur_version, 8'($urandom_range(255)), 16'($urandom_range(65535)),
                 16'($urandom_range(65535)), $urandom, size);
      packets_built++;
      headers_dropped++;
    end
  endfunction

  // Dropped header whose sequence field holds the magic: the rescan finds it,
  // and the dropped size bytes become version, type and width of a new header
  // that the following bytes complete.
  function automatic void put_nested_header();
    logic [7:0]  t2;
    logic [15:0] w2;
    logic [31:0] size;
    t2   = 8'($urandom_range(255));
    w2   = 16'($urandom_range(65535));
    size = pick_size();
    put_header(cur_version ^ 8'($urandom_range(255, 1)), 8'($urandom_range(255)),
               16'($urandom_range(65535)), 16'($urandom_range(65535)), SYNC_WORD,
               {w2, t2, cur_version});
    put_le(32'($urandom_range(65535)), 2);
    put_le($urandom, 4);
    put_le(size, 4);
    put_payload(size);
    packets_built += 2;
    headers_dropped++;
  endfunction

  // Mix of well-formed packets with random content, dropped headers, false
  // magic starts and line noise.
  function automatic void build_traffic(input int n_bytes);
    int pick;
    int target;
    target = stream_q.size() + n_bytes;
    while (stream_q.size() < target) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        put_good_packet(pick_size());
      end else if (pick < 68) begin
        put_bad_version();
      end else if (pick < 78) begin
        put_bad_size();
      end else if (pick < 84) begin
        put_nested_header();
      end else if (pick < 92) begin
        // partial magic, then a real one: the match restarts on 'T'
        put_le(SYNC_WORD, $urandom_range(3, 1));
        put_good_packet(pick_size());
      end else begin
        for (int i = $urandom_range(8, 1); i > 0; i--)
          stream_q.push_back(8'($urandom_range(255)));
      end
    end
  endfunction

  // Push every queued byte; hold the beat while full is high.
  task automatic stream_out();
    bit done;
    done = 1'b0;
    while (!done) begin
      @(posedge clk);
      if (push && !full) begin
        void'(stream_q.pop_front());
        bytes_sent++;
      end
      if (stream_q.size() == 0) begin
        push <= 1'b0;
        done = 1'b1;
      end else if (!(push && full)) begin
        if ($urandom_range(99) < tx_idle_pct) begin
          push <= 1'b0;
        end else begin
          push       <= 1'b1;
          in_rx_byte <= stream_q[0];
        end
      end
    end
  endtask

  // Drain every predicted beat, then let any replay finish.
  task automatic wait_quiet();
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] ver, input logic [31:0] lim);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_EXPECTED_VERSION;
    cfg_data  <= {24'h0, ver};
    @(posedge clk);
    cfg_index <= REG_PAYLOAD_LIMIT;
    cfg_data  <= lim;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    cur_version = ver;
    cur_limit   = lim;
    settings_used++;
  endtask

  initial begin : stimulus
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: byte extremes, a doubled 'T' before the magic, then an empty
    // packet with extreme header fields at the reset configuration.
    tx_idle_pct = 33;
    rx_idle_pct = 60;
    stream_q.push_back(8'h00);
    stream_q.push_back(8'hFF);
    stream_q.push_back(MAGIC_0);
    put_header(VERSION_RESET, 8'hFF, 16'hFFFF, 16'h0000, 32'hFFFF_FFFF, 32'd0);
    packets_built++;
    stream_out();

    // Reset configuration, sender sparse, receiver sparser.
    build_traffic(420);
    stream_out();

    // Lowest settings: only empty packets pass. Idling swapped.
    wait_quiet();
    set_config(8'd0, 32'd0);
    tx_idle_pct = 60;
    rx_idle_pct = 33;
    build_traffic(400);
    stream_out();

    // Highest settings, no idling. Hold the receiver off while a long packet
    // streams in, so the result queue fills and full backs up the sender.
    wait_quiet();
    set_config(8'd255, 32'hFFFF_FFFF);
    tx_idle_pct  = 0;
    rx_idle_pct  = 0;
    rx_stall_req = 300;
    put_good_packet(32'd40);
    build_traffic(400);
    stream_out();

    // Random version with a tight limit.
    wait_quiet();
    set_config(8'($urandom_range(255)), 32'($urandom_range(20)));
    build_traffic(400);
    stream_out();

    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run covered %0d stream bytes, %0d packets built (%0d headers dropped),",
             bytes_sent, packets_built, headers_dropped);
    $display("%0d result beats checked across %0d configuration settings.",
             beats_checked, settings_used);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
src/mspd_pkg.sv
src/mspd_front.sv
src/mspd_queue.sv
src/magic_sync_packet_deframer_unit.sv
tb/deframer_checker.sv
tb/tb.sv
